// ===== rtl/hsfc_pkg.sv =====
package hsfc_pkg;

  // Direction codes carried in the command field.
  localparam logic CmdHalfToSingle = 1'b0;
  localparam logic CmdSingleToHalf = 1'b1;

  localparam int unsigned OperandWidth = 32;
  localparam int unsigned ResultWidth  = 32;

  typedef struct packed {
    logic                    command;
    logic [OperandWidth-1:0] operand_bits;
  } hsfc_req_t;

  typedef struct packed {
    logic [ResultWidth-1:0] result_bits;
  } hsfc_rsp_t;

  // Half to single conversion. The result is exact.
  function automatic logic [31:0] half_to_single(input logic [15:0] h);
    logic        sgn;
    logic [4:0]  ex;
    logic [9:0]  mn;
    logic [3:0]  lz;
    logic [10:0] norm;
    logic [7:0]  sexp;
    logic [31:0] res;
    sgn  = h[15];
    ex   = h[14:10];
    mn   = h[9:0];
    lz   = 4'd0;
    norm = 11'd0;
    sexp = 8'd0;
    // Normalization shift of a subnormal: the leading-zero count of {1'b0, mn}.
    for (int i = 0; i < 10; i++) begin
      if (mn[i]) begin
        lz = 4'(10 - i);
      end
    end
    norm = {1'b0, mn} << lz;
    sexp = 8'd113 - 8'(lz);
    if (ex == 5'd0) begin
      if (mn == 10'd0) begin
        res = {sgn, 31'd0};
      end else begin
        res = {sgn, sexp, norm[9:0], 13'd0};
      end
    end else if (ex == 5'h1F) begin
      res = {sgn, 8'hFF, mn, 13'd0};
    end else begin
      res = {sgn, 8'(ex) + 8'd112, mn, 13'd0};
    end
    return res;
  endfunction

  // Single to half conversion with truncation; overflow and NaN give infinity.
  function automatic logic [15:0] single_to_half(input logic [31:0] s);
    logic        sgn;
    logic [8:0]  ex;
    logic [23:0] sig;
    logic [4:0]  sh;
    logic [23:0] shifted;
    logic [15:0] res;
    sgn     = s[31];
    ex      = {1'b0, s[30:23]} - 9'd112;
    sig     = {1'b1, s[22:0]};
    sh      = 5'd0;
    shifted = 24'd0;
    if (s[30:23] >= 8'd143) begin
      res = {sgn, 15'h7C00};
    end else if (s[30:23] <= 8'd112) begin
      if (s[30:23] < 8'd102) begin
        res = {sgn, 15'd0};
      end else begin
        // Shift count is 14 - ex, which lies in 14 to 24.
        sh      = 5'(8'd126 - s[30:23]);
        shifted = sig >> sh;
        res     = {sgn, shifted[14:0]};
      end
    end else begin
      res = {sgn, ex[4:0], s[22:13]};
    end
    return res;
  endfunction

endpackage

// ===== rtl/hsfc_if.sv =====
interface hsfc_req_if;
  import hsfc_pkg::*;
  logic      valid;
  logic      ready;
  hsfc_req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface hsfc_rsp_if;
  import hsfc_pkg::*;
  logic      valid;
  logic      ready;
  hsfc_rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/half_single_float_convert_core.sv =====
// Half/single floating-point converter.
// Requests arrive on req_i: command selects half to single (exact) or
// single to half (truncating), operand_bits holds the source pattern.
// Results leave on rsp_o as result_bits; a half result sits in the low
// 16 bits with the upper bits zero.
// The request is registered on acceptance; the conversion is short
// combinational logic from that register to the result register.
// A request passes the input register and then the result register before
// its result is valid; one request can be accepted every cycle while results drain.
// A second stage register lets the input register keep moving while a
// finished result waits: ready drops only when both stages are full.
// When the receiver stalls, results hold in place and stay valid.
// Reset is asynchronous and empties both stages; the block is ready
// as soon as reset is released.
module half_single_float_convert_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  hsfc_req_if.sink    req_i,
  hsfc_rsp_if.source  rsp_o
);
  import hsfc_pkg::*;

  logic        in_vld_q, in_vld_d;
  hsfc_req_t   in_q;
  logic        out_vld_q, out_vld_d;
  logic [31:0] out_q;
  logic [31:0] conv;
  logic        out_load;
  logic        in_load;

  // The result stage takes new data when it is empty or being drained.
  assign out_load = !out_vld_q || rsp_o.ready;
  assign req_i.ready = !in_vld_q || out_load;
  assign in_load = req_i.valid && req_i.ready;

  // Conversion between the two registers.
  always_comb begin
    unique case (in_q.command)
      CmdHalfToSingle: conv = half_to_single(in_q.operand_bits[15:0]);
      CmdSingleToHalf: conv = {16'd0, single_to_half(in_q.operand_bits)};
      default:         conv = '0;
    endcase
  end

  assign in_vld_d  = in_load ? 1'b1 : (out_load ? 1'b0 : in_vld_q);
  assign out_vld_d = out_load ? in_vld_q : out_vld_q;

  // Valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_load) begin
      in_q <= req_i.payload;
    end
    if (out_load && in_vld_q) begin
      out_q <= conv;
    end
  end

  assign rsp_o.valid = out_vld_q;
  assign rsp_o.payload.result_bits = out_q;

`ifndef SYNTHESIS
  // A stalled result must not change.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !rsp_o.ready |=> out_vld_q && $stable(out_q))
    else $error("result changed under stall");
  // With both stages full and the output stalled, no request is taken.
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && out_vld_q && !rsp_o.ready |-> !req_i.ready)
    else $error("request taken while full");
  // Half results keep the upper bits clear.
  a_upper: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && in_q.command == CmdSingleToHalf |-> conv[31:16] == 16'd0)
    else $error("half result upper bits set");
`endif

endmodule
